[rtl/core/pta_pkg.sv]
// pta_pkg: shared types and constants for the point track association block
// holds the table size, field widths, register indexes and the sequencer state type
// no dependencies
package pta_pkg;

    localparam int MAX_TRACKS = 8;
    localparam int IDX_W      = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);

    localparam int X_W    = 10;
    localparam int Y_W    = 9;
    localparam int THR_W  = 11;
    localparam int SPAN_W = 11;
    localparam int OIDX_W = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(50);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_THR  = 2'd0,
        CFG_MOTION_THR = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SPAN,
        ST_OUT
    } state_t;

endpackage

[rtl/core/point_track_association_top.sv]
// point_track_association_top: associates detected points with a small table of tracks
// one shared distance/compare unit under a sequencer walks the table one entry a cycle
// depends on pta_pkg
//
// usage
// - configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the match
//   threshold (index 0) and motion threshold (index 1); other indexes are ignored;
//   cfg_ready is always high, writes are meant for when the block is idle
// - input channel (in_valid/in_ready, point_x, point_y) takes one point request;
//   in_ready is high only while the sequencer is idle
// - output channel (out_valid/out_ready) carries one result per request:
//   track_index, opened_track, dropped, track_span, motionless
// - after acceptance the sequencer scans every table entry through the distance unit,
//   then updates the box and calculates the span (no span step if dropped), then
//   raises out_valid; only one request is in flight at a time
// - a stalled receiver holds the result registers and out_valid; no new request is
//   taken until the result is accepted
// - reset clears all track valid bits, the track count and returns both thresholds to 50;
//   the coordinate and box stores are not cleared, entries are written before use
module point_track_association_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pta_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pta_pkg::THR_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pta_pkg::X_W-1:0]      point_x,
    input  logic [pta_pkg::Y_W-1:0]      point_y,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pta_pkg::OIDX_W-1:0]   track_index,
    output logic                         opened_track,
    output logic                         dropped,
    output logic [pta_pkg::SPAN_W-1:0]   track_span,
    output logic                         motionless
);
    import pta_pkg::*;

    state_t state_reg, state_next;

    logic [THR_W-1:0] match_thr_reg, motion_thr_reg;

    logic [MAX_TRACKS-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic [X_W-1:0] last_x_mem [MAX_TRACKS];
    logic [Y_W-1:0] last_y_mem [MAX_TRACKS];
    logic [X_W-1:0] min_x_mem  [MAX_TRACKS];
    logic [X_W-1:0] max_x_mem  [MAX_TRACKS];
    logic [Y_W-1:0] min_y_mem  [MAX_TRACKS];
    logic [Y_W-1:0] max_y_mem  [MAX_TRACKS];

    logic [X_W-1:0]   px_reg, px_next;
    logic [Y_W-1:0]   py_reg, py_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic             hit_found_reg, hit_found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             slot_found_reg, slot_found_next;
    logic [IDX_W-1:0] slot_idx_reg, slot_idx_next;

    logic [X_W-1:0] nminx_reg, nminx_next, nmaxx_reg, nmaxx_next;
    logic [Y_W-1:0] nminy_reg, nminy_next, nmaxy_reg, nmaxy_next;

    logic [OIDX_W-1:0] oidx_reg, oidx_next;
    logic              oopen_reg, oopen_next;
    logic              odrop_reg, odrop_next;
    logic [SPAN_W-1:0] ospan_reg, ospan_next;
    logic              ostill_reg, ostill_next;

    // shared distance unit
    logic [X_W-1:0]   dx;
    logic [Y_W-1:0]   dy;
    logic [THR_W-1:0] gap_sum;
    logic             in_gate;

    // table write port
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_open;

    logic [SPAN_W-1:0] span;

    always_comb
    begin
        dx = (px_reg >= last_x_mem[scan_reg]) ? px_reg - last_x_mem[scan_reg]
                                               : last_x_mem[scan_reg] - px_reg;
        dy = (py_reg >= last_y_mem[scan_reg]) ? py_reg - last_y_mem[scan_reg]
                                               : last_y_mem[scan_reg] - py_reg;
        gap_sum = THR_W'(dx) + THR_W'(dy);
        in_gate = (gap_sum <= match_thr_reg);
        span    = SPAN_W'(nmaxx_reg - nminx_reg) + SPAN_W'(nmaxy_reg - nminy_reg);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_thr_reg  <= THR_RESET;
            motion_thr_reg <= THR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MATCH_THR:  match_thr_reg  <= cfg_data;
                CFG_MOTION_THR: motion_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        scan_next       = scan_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        slot_found_next = slot_found_reg;
        slot_idx_next   = slot_idx_reg;
        nminx_next      = nminx_reg;
        nmaxx_next      = nmaxx_reg;
        nminy_next      = nminy_reg;
        nmaxy_next      = nmaxy_reg;
        oidx_next       = oidx_reg;
        oopen_next      = oopen_reg;
        odrop_next      = odrop_reg;
        ospan_next      = ospan_reg;
        ostill_next     = ostill_reg;
        wr_en           = 1'b0;
        wr_open         = 1'b0;
        wr_idx          = hit_idx_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    px_next         = point_x;
                    py_next         = point_y;
                    scan_next       = '0;
                    hit_found_next  = 1'b0;
                    slot_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (valid_reg[scan_reg])
                begin
                    if (!hit_found_reg && in_gate)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = scan_reg;
                    end
                end
                else if (!slot_found_reg)
                begin
                    slot_found_next = 1'b1;
                    slot_idx_next   = scan_reg;
                end
                if (scan_reg == IDX_W'(MAX_TRACKS - 1))
                    state_next = ST_UPDATE;
                else
                    scan_next = scan_reg + 1'b1;
            end
            ST_UPDATE:
            begin
                if (hit_found_reg)
                begin
                    wr_en      = 1'b1;
                    wr_idx     = hit_idx_reg;
                    nminx_next = (px_reg < min_x_mem[hit_idx_reg]) ? px_reg
                                                                   : min_x_mem[hit_idx_reg];
                    nmaxx_next = (px_reg > max_x_mem[hit_idx_reg]) ? px_reg
                                                                   : max_x_mem[hit_idx_reg];
                    nminy_next = (py_reg < min_y_mem[hit_idx_reg]) ? py_reg
                                                                   : min_y_mem[hit_idx_reg];
                    nmaxy_next = (py_reg > max_y_mem[hit_idx_reg]) ? py_reg
                                                                   : max_y_mem[hit_idx_reg];
                    oidx_next  = OIDX_W'(hit_idx_reg);
                    oopen_next = 1'b0;
                    odrop_next = 1'b0;
                    state_next = ST_SPAN;
                end
                else if (count_reg < CNT_W'(MAX_TRACKS) && slot_found_reg)
                begin
                    wr_en      = 1'b1;
                    wr_open    = 1'b1;
                    wr_idx     = slot_idx_reg;
                    valid_next[slot_idx_reg] = 1'b1;
                    count_next = count_reg + 1'b1;
                    nminx_next = px_reg;
                    nmaxx_next = px_reg;
                    nminy_next = py_reg;
                    nmaxy_next = py_reg;
                    oidx_next  = OIDX_W'(slot_idx_reg);
                    oopen_next = 1'b1;
                    odrop_next = 1'b0;
                    state_next = ST_SPAN;
                end
                else
                begin
                    // table full, point discarded
                    oidx_next   = '0;
                    oopen_next  = 1'b0;
                    odrop_next  = 1'b1;
                    ospan_next  = '0;
                    ostill_next = 1'b0;
                    state_next  = ST_OUT;
                end
            end
            ST_SPAN:
            begin
                ospan_next  = span;
                ostill_next = (span <= motion_thr_reg);
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        scan_reg       <= scan_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        slot_found_reg <= slot_found_next;
        slot_idx_reg   <= slot_idx_next;
        nminx_reg      <= nminx_next;
        nmaxx_reg      <= nmaxx_next;
        nminy_reg      <= nminy_next;
        nmaxy_reg      <= nmaxy_next;
        oidx_reg       <= oidx_next;
        oopen_reg      <= oopen_next;
        odrop_reg      <= odrop_next;
        ospan_reg      <= ospan_next;
        ostill_reg     <= ostill_next;
    end

    // track table, written at most once per request (not written when the point is dropped)
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            last_x_mem[wr_idx] <= px_reg;
            last_y_mem[wr_idx] <= py_reg;
            min_x_mem[wr_idx]  <= wr_open ? px_reg : nminx_next;
            max_x_mem[wr_idx]  <= wr_open ? px_reg : nmaxx_next;
            min_y_mem[wr_idx]  <= wr_open ? py_reg : nminy_next;
            max_y_mem[wr_idx]  <= wr_open ? py_reg : nmaxy_next;
        end
    end

    assign track_index  = oidx_reg;
    assign opened_track = oopen_reg;
    assign dropped      = odrop_reg;
    assign track_span   = ospan_reg;
    assign motionless   = ostill_reg;

endmodule

[dv/tb_top.sv]
// tb_top: self-checking bench for point_track_association_top, directed rows then random points
// keeps its own copy of the track table to predict each result, with idle and stall phases
// depends on pta_pkg and the rtl of point_track_association_top
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pta_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * (MAX_TRACKS + 4);
    localparam int CHUNK_ITEMS  = 105;
    localparam int NOISE_PCT    = 20;
    localparam int X_TOP        = (1 << X_W) - 1;
    localparam int Y_TOP        = (1 << Y_W) - 1;
    localparam int THR_TOP      = (1 << THR_W) - 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [OIDX_W-1:0] idx;
        logic              opened;
        logic              drop;
        logic [SPAN_W-1:0] span;
        logic              still;
    } assoc_res_t;

    typedef enum bit {
        ROW_POINT,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [THR_W-1:0]     reg_val;
        logic [X_W-1:0]       x;
        logic [Y_W-1:0]       y;
        logic                 typed;
        assoc_res_t           res;
    } stim_row_t;

    function automatic stim_row_t row_point(input int x, input int y);
        stim_row_t r;
        r = '0;
        r.kind = ROW_POINT;
        r.x = X_W'(x);
        r.y = Y_W'(y);
        return r;
    endfunction

    function automatic stim_row_t row_known(input int x, input int y, input int idx,
                                            input int opened, input int drop,
                                            input int span, input int still);
        stim_row_t r;
        r = row_point(x, y);
        r.typed = 1'b1;
        r.res.idx = OIDX_W'(idx);
        r.res.opened = opened[0];
        r.res.drop = drop[0];
        r.res.span = SPAN_W'(span);
        r.res.still = still[0];
        return r;
    endfunction

    function automatic stim_row_t row_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = THR_W'(val);
        return r;
    endfunction

    localparam stim_row_t DIRECTED [24] = '{
        row_known(0, 0, 0, 1, 0, 0, 1),
        row_known(X_TOP, Y_TOP, 1, 1, 0, 0, 1),
        row_known(10, 20, 0, 0, 0, 30, 1),
        // distance exactly on the gate
        row_known(40, 40, 0, 0, 0, 80, 0),
        row_point(91, 40),
        row_write(CFG_MATCH_THR, 0),
        row_point(91, 40),
        row_point(92, 40),
        // spare index must not touch either threshold
        row_write(CFG_SPARE_IDX, THR_TOP),
        row_known(40, 40, 0, 0, 0, 80, 0),
        row_write(CFG_MATCH_THR, THR_TOP),
        // lowest index wins over a nearer track
        row_point(95, 40),
        row_write(CFG_MOTION_THR, 0),
        row_known(X_TOP, Y_TOP, 0, 0, 0, X_TOP + Y_TOP, 0),
        row_write(CFG_MOTION_THR, THR_TOP),
        row_known(X_TOP, Y_TOP, 0, 0, 0, X_TOP + Y_TOP, 1),
        row_write(CFG_MATCH_THR, 0),
        row_point(300, 100),
        row_point(300, 200),
        row_point(300, 300),
        row_point(0, Y_TOP),
        // table full, no match
        row_known(500, 100, 0, 0, 1, 0, 0),
        row_point(0, Y_TOP),
        row_point(X_TOP, 0)
    };

    localparam logic [THR_W-1:0] GATE_SET  [9] = '{0, 2047, 50, 12, 150, 2047, 0, 300, 25};
    localparam logic [THR_W-1:0] STILL_SET [9] = '{2047, 0, 50, 400, 20, 2047, 0, 1000, 120};
    localparam int SEND_IDLE [3] = '{14, 60, 0};
    localparam int RECV_IDLE [3] = '{60, 14, 0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [THR_W-1:0]      cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [X_W-1:0]        point_x = '0;
    logic [Y_W-1:0]        point_y = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [OIDX_W-1:0]     track_index;
    logic                  opened_track;
    logic                  dropped;
    logic [SPAN_W-1:0]     track_span;
    logic                  motionless;

    // predictor copy of the track table and thresholds
    logic                  trk_live [MAX_TRACKS] = '{default: 1'b0};
    logic [X_W-1:0]        trk_x    [MAX_TRACKS];
    logic [Y_W-1:0]        trk_y    [MAX_TRACKS];
    logic [X_W-1:0]        box_x_lo [MAX_TRACKS];
    logic [X_W-1:0]        box_x_hi [MAX_TRACKS];
    logic [Y_W-1:0]        box_y_lo [MAX_TRACKS];
    logic [Y_W-1:0]        box_y_hi [MAX_TRACKS];
    logic [THR_W-1:0]      gate_thr = THR_RESET;
    logic [THR_W-1:0]      still_thr = THR_RESET;

    assoc_res_t            expected_assoc [$];
    assoc_res_t            oldest_assoc;
    assoc_res_t            typed_res = '0;
    logic                  typed_hold = 1'b0;
    int                    results_due = 0;
    int                    points_sent = 0;
    int                    points_taken = 0;
    int                    failures = 0;
    int                    cycle_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;

    point_track_association_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .point_x      (point_x),
        .point_y      (point_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .track_index  (track_index),
        .opened_track (opened_track),
        .dropped      (dropped),
        .track_span   (track_span),
        .motionless   (motionless)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int axis_gap(input int a, input int b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic assoc_res_t associate_point(input logic [X_W-1:0] px,
                                                   input logic [Y_W-1:0] py);
        assoc_res_t r;
        int hit;
        int slot;
        int span;
        r = '0;
        hit = -1;
        slot = -1;
        for (int i = 0; i < MAX_TRACKS; i++)
        begin
            if (trk_live[i])
            begin
                if (hit < 0 && axis_gap(int'(px), int'(trk_x[i]))
                             + axis_gap(int'(py), int'(trk_y[i])) <= int'(gate_thr))
                    hit = i;
            end
            else if (slot < 0)
            begin
                slot = i;
            end
        end
        if (hit < 0 && slot < 0)
        begin
            r.drop = 1'b1;
            return r;
        end
        if (hit < 0)
        begin
            hit = slot;
            r.opened = 1'b1;
            trk_live[hit] = 1'b1;
            box_x_lo[hit] = px;
            box_x_hi[hit] = px;
            box_y_lo[hit] = py;
            box_y_hi[hit] = py;
        end
        else
        begin
            if (px < box_x_lo[hit]) box_x_lo[hit] = px;
            if (px > box_x_hi[hit]) box_x_hi[hit] = px;
            if (py < box_y_lo[hit]) box_y_lo[hit] = py;
            if (py > box_y_hi[hit]) box_y_hi[hit] = py;
        end
        trk_x[hit] = px;
        trk_y[hit] = py;
        span = (int'(box_x_hi[hit]) - int'(box_x_lo[hit]))
             + (int'(box_y_hi[hit]) - int'(box_y_lo[hit]));
        r.idx = OIDX_W'(hit);
        r.span = SPAN_W'(span);
        r.still = (span <= int'(still_thr));
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (results_due == 0)
                begin
                    $error("association result with no request outstanding");
                    failures++;
                end
                else
                begin
                    oldest_assoc = expected_assoc.pop_front();
                    results_due--;
                    check_field("track_index", 32'(oldest_assoc.idx), 32'(track_index));
                    check_field("opened_track", 32'(oldest_assoc.opened), 32'(opened_track));
                    check_field("dropped", 32'(oldest_assoc.drop), 32'(dropped));
                    check_field("track_span", 32'(oldest_assoc.span), 32'(track_span));
                    check_field("motionless", 32'(oldest_assoc.still), 32'(motionless));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MATCH_THR)
                    gate_thr = cfg_data;
                else if (cfg_index == CFG_MOTION_THR)
                    still_thr = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                oldest_assoc = associate_point(point_x, point_y);
                if (typed_hold)
                    oldest_assoc = typed_res;
                expected_assoc = {expected_assoc, oldest_assoc};
                results_due++;
                points_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        in_valid <= 1'b0;
        wait (results_due == 0);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_point(input logic [X_W-1:0] x, input logic [Y_W-1:0] y,
                              input logic typed, input assoc_res_t res);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        typed_hold = typed;
        typed_res = res;
        in_valid <= 1'b1;
        point_x <= x;
        point_y <= y;
        points_sent++;
        wait (points_taken == points_sent);
    endtask

    initial
    begin
        int pick;
        int reach;
        int budget;
        int dx;
        int px;
        int py;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = SEND_IDLE[0];
        recv_idle_pct = RECV_IDLE[0];

        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
            else
                send_point(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].typed, DIRECTED[i].res);
        end

        for (int c = 0; c < $size(GATE_SET); c++)
        begin
            send_idle_pct = SEND_IDLE[c / 3];
            recv_idle_pct = RECV_IDLE[c / 3];
            write_reg(CFG_MATCH_THR, GATE_SET[c]);
            write_reg(CFG_MOTION_THR, STILL_SET[c]);
            reach = int'(GATE_SET[c]) + int'(GATE_SET[c]) / 4 + 4;
            if (reach > 600)
                reach = 600;
            repeat (CHUNK_ITEMS)
            begin
                pick = $urandom_range(0, MAX_TRACKS - 1);
                if ($urandom_range(0, 99) < NOISE_PCT || !trk_live[pick])
                begin
                    px = $urandom_range(0, X_TOP);
                    py = $urandom_range(0, Y_TOP);
                end
                else
                begin
                    // jitter around a live track, split between the two axes
                    budget = $urandom_range(0, reach);
                    dx = $urandom_range(0, budget);
                    px = int'(trk_x[pick]) + ($urandom_range(0, 1) ? dx : -dx);
                    py = int'(trk_y[pick]) + ($urandom_range(0, 1) ? budget - dx : dx - budget);
                    if (px < 0) px = 0;
                    if (px > X_TOP) px = X_TOP;
                    if (py < 0) py = 0;
                    if (py > Y_TOP) py = Y_TOP;
                end
                send_point(X_W'(px), Y_W'(py), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
